// ----- src/stable_sorted_ready_queue_top_assert.svh -----
// assertion macros for the stable sorted ready queue
// used by stable_sorted_ready_queue_top, no other dependencies
`ifndef STABLE_SORTED_READY_QUEUE_TOP_ASSERT_SVH
`define STABLE_SORTED_READY_QUEUE_TOP_ASSERT_SVH

// property checked on every rising clock edge outside reset
`define SSRQ_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

`endif

// ----- src/ssrq_pkg.sv -----
// shared types and constants of the stable sorted ready queue
// no dependencies
package ssrq_pkg;

  localparam int QueueDepth = 16;
  localparam int FillW      = $clog2(QueueDepth + 1);
  localparam int IdW        = 8;
  localparam int KeyW       = 16;

  typedef enum logic {
    ActInsert = 1'b0,
    ActRemove = 1'b1
  } action_e;

  typedef enum logic [1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef struct packed {
    logic [IdW-1:0]  id;
    logic [KeyW-1:0] key;
  } slot_t;

  typedef struct packed {
    logic  insert;
    logic  remove;
    logic  mode;
    slot_t ent;
  } cell_ctrl_t;

endpackage

// ----- src/stable_sorted_ready_queue_top.sv -----
// stable sorted ready queue, top level: fill count, cell row and result register
// depends on ssrq_pkg, ssrq_cell and stable_sorted_ready_queue_top_assert.svh
// result: the result strobe is registered from start_i and rises in the cycle after the start transaction
// throughput: one transaction per cycle, busy_o stays low
// reset: fill count cleared to empty and order mode to append, slot contents not cleared
// results cannot be held off by the receiver
`include "stable_sorted_ready_queue_top_assert.svh"

module stable_sorted_ready_queue_top import ssrq_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            order_mode_we_i,
  input  logic            order_mode_i,
  input  logic            start_i,
  output logic            busy_o,
  input  logic            action_i,
  input  logic [IdW-1:0]  entry_id_i,
  input  logic [KeyW-1:0] sort_key_i,
  output logic            done_o,
  output logic [IdW-1:0]  head_id_o,
  output logic [KeyW-1:0] head_key_o,
  output logic [FillW-1:0] occupancy_o,
  output logic [1:0]      status_o
);

  logic             mode_q;
  logic [FillW-1:0] fill_q, fill_d;
  logic             done_q;
  slot_t            res_slot_q, res_slot_d;
  logic [FillW-1:0] res_occ_q;
  status_e          res_status_q, res_status_d;

  cell_ctrl_t       ctrl;
  slot_t            new_ent;
  slot_t            slots  [QueueDepth];
  slot_t            lefts  [QueueDepth];
  slot_t            rights [QueueDepth];
  logic [QueueDepth:0] take;
  logic             is_insert, full, empty, new_first;

  assign busy_o    = 1'b0;
  assign is_insert = (action_e'(action_i) == ActInsert);
  assign full      = (fill_q == FillW'(QueueDepth));
  assign empty     = (fill_q == '0);
  assign new_ent   = '{id: entry_id_i, key: sort_key_i};

  assign ctrl.insert = start_i & is_insert & ~full;
  assign ctrl.remove = start_i & ~is_insert & ~empty;
  assign ctrl.mode   = mode_q;
  assign ctrl.ent    = new_ent;

  assign take[0] = 1'b0;

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lefts[i] = new_ent;
    end else begin : g_mid_l
      assign lefts[i] = slots[i-1];
    end
    if (i == QueueDepth - 1) begin : g_last
      assign rights[i] = slots[i];
    end else begin : g_mid_r
      assign rights[i] = slots[i+1];
    end

    ssrq_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .valid_i (fill_q > FillW'(i)),
      .tail_i  (fill_q == FillW'(i)),
      .take_i  (take[i]),
      .take_o  (take[i+1]),
      .left_i  (lefts[i]),
      .right_i (rights[i]),
      .slot_o  (slots[i])
    );
  end

  assign new_first = empty | (mode_q & (slots[0].key > sort_key_i));

  always_comb begin
    fill_d       = fill_q;
    res_slot_d   = slots[0];
    res_status_d = StatusOk;
    if (is_insert) begin
      if (full) begin
        res_status_d = StatusFull;
      end else begin
        fill_d = fill_q + FillW'(1);
        if (new_first) begin
          res_slot_d = new_ent;
        end
      end
    end else begin
      if (empty) begin
        res_status_d = StatusEmpty;
        res_slot_d   = '0;
      end else begin
        fill_d = fill_q - FillW'(1);
        if (fill_q == FillW'(1)) begin
          res_slot_d = slots[0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      if (order_mode_we_i) begin
        mode_q <= order_mode_i;
      end
      done_q <= start_i;
      if (start_i) begin
        fill_q <= fill_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      res_slot_q   <= res_slot_d;
      res_occ_q    <= fill_d;
      res_status_q <= res_status_d;
    end
  end

  assign done_o      = done_q;
  assign head_id_o   = res_slot_q.id;
  assign head_key_o  = res_slot_q.key;
  assign occupancy_o = res_occ_q;
  assign status_o    = res_status_q;

  `SSRQ_ASSERT(a_done_follows_start, start_i |=> done_o, "result strobe missing after start")
  `SSRQ_ASSERT(a_fill_bound, fill_q <= FillW'(QueueDepth), "fill count above depth")
  `SSRQ_ASSERT(a_full_occ, (done_o && status_o == StatusFull) |-> (occupancy_o == FillW'(QueueDepth)), "full status with queue not full")
  `SSRQ_ASSERT(a_insert_grows, (start_i && is_insert && !full) |=> (fill_q == $past(fill_q) + FillW'(1)), "insert did not grow fill count")

endmodule

// ----- src/ssrq_cell.sv -----
// one queue slot: holds an entry, compares its key and shifts with its neighbors
// depends on ssrq_pkg
module ssrq_cell import ssrq_pkg::*; (
  input  logic       clk_i,
  input  cell_ctrl_t ctrl_i,
  input  logic       valid_i,
  input  logic       tail_i,
  input  logic       take_i,
  output logic       take_o,
  input  slot_t      left_i,
  input  slot_t      right_i,
  output slot_t      slot_o
);

  slot_t slot_q, slot_d;
  logic  here;

  assign here   = valid_i & ctrl_i.mode & (slot_q.key > ctrl_i.ent.key);
  assign take_o = take_i | here;

  always_comb begin
    slot_d = slot_q;
    if (ctrl_i.insert) begin
      if (take_i) begin
        slot_d = left_i;
      end else if (here || tail_i) begin
        slot_d = ctrl_i.ent;
      end
    end else if (ctrl_i.remove) begin
      slot_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign slot_o = slot_q;

endmodule
